// ===== src/pse_pkg.sv =====
// Package with codes, sizes and the control program of the postfix stack evaluator.
`timescale 1ns / 1ps

package pse_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int NUM_VARS        = 26;
    localparam int DATA_W          = 32;
    localparam int VIDX_W          = 5;
    localparam int DEPTH_OUT_W     = 7;
    localparam int DIV_STEPS       = 32;
    localparam int DIV_CNT_W       = $clog2(DIV_STEPS);
    localparam int PC_W            = 4;

    localparam logic [1:0] CMD_PUSH_LIT = 2'd0;
    localparam logic [1:0] CMD_PUSH_VAR = 2'd1;
    localparam logic [1:0] CMD_APPLY    = 2'd2;
    localparam logic [1:0] CMD_STORE    = 2'd3;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_DIV_ZERO  = 2'd3;

    localparam logic [PC_W-1:0] STEP_WAIT   = 4'd0;
    localparam logic [PC_W-1:0] STEP_CHECK  = 4'd1;
    localparam logic [PC_W-1:0] STEP_PUSH   = 4'd2;
    localparam logic [PC_W-1:0] STEP_ALU    = 4'd3;
    localparam logic [PC_W-1:0] STEP_DIV    = 4'd4;
    localparam logic [PC_W-1:0] STEP_FIX    = 4'd5;
    localparam logic [PC_W-1:0] STEP_WB     = 4'd6;
    localparam logic [PC_W-1:0] STEP_STORE  = 4'd7;
    localparam logic [PC_W-1:0] STEP_REPORT = 4'd8;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_CHECK,
        ACT_PUSH,
        ACT_ALU,
        ACT_DIV,
        ACT_FIX,
        ACT_WB,
        ACT_STORE,
        ACT_REPORT
    } t_act;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_GOTO,
        JMP_ACCEPT,
        JMP_DECODE,
        JMP_DIVSEL,
        JMP_DIVLOOP,
        JMP_OUT
    } t_jmp;

    typedef struct packed {
        logic            ready;
        t_act            act;
        t_jmp            jmp;
        logic [PC_W-1:0] target;
    } t_ctrl;

    function automatic t_ctrl program_rom(input logic [PC_W-1:0] pc);
        t_ctrl c;
        c = '{ready: 1'b0, act: ACT_NONE, jmp: JMP_GOTO, target: STEP_WAIT};
        case (pc)
            STEP_WAIT:   c = '{ready: 1'b1, act: ACT_NONE,   jmp: JMP_ACCEPT,
                               target: STEP_CHECK};
            STEP_CHECK:  c = '{ready: 1'b0, act: ACT_CHECK,  jmp: JMP_DECODE,
                               target: STEP_REPORT};
            STEP_PUSH:   c = '{ready: 1'b0, act: ACT_PUSH,   jmp: JMP_GOTO,
                               target: STEP_REPORT};
            STEP_ALU:    c = '{ready: 1'b0, act: ACT_ALU,    jmp: JMP_DIVSEL,
                               target: STEP_WB};
            STEP_DIV:    c = '{ready: 1'b0, act: ACT_DIV,    jmp: JMP_DIVLOOP,
                               target: STEP_FIX};
            STEP_FIX:    c = '{ready: 1'b0, act: ACT_FIX,    jmp: JMP_NEXT,
                               target: STEP_WB};
            STEP_WB:     c = '{ready: 1'b0, act: ACT_WB,     jmp: JMP_GOTO,
                               target: STEP_REPORT};
            STEP_STORE:  c = '{ready: 1'b0, act: ACT_STORE,  jmp: JMP_GOTO,
                               target: STEP_REPORT};
            STEP_REPORT: c = '{ready: 1'b0, act: ACT_REPORT, jmp: JMP_OUT,
                               target: STEP_WAIT};
            default:     c = '{ready: 1'b0, act: ACT_NONE,   jmp: JMP_GOTO,
                               target: STEP_WAIT};
        endcase
        return c;
    endfunction

endpackage

// ===== src/pse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ===== src/postfix_stack_evaluator.sv =====
// Top level of the postfix stack evaluator, a microcoded sequencer over a stack datapath.
// A checked item goes to the report step on a fault, else to push, store, or the ALU step
// (for divide then the 32-step restoring divider and a sign fix) and write-back, then report.
// Only the wait step accepts input, so a new item is taken after the last is reported.
// Reset (synchronous, active low) empties the stack and clears all 26 variables at once;
// stack memory contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module postfix_stack_evaluator
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // Bits from low: literal_value[31:0], var_index[36:32], op_code[38:37], zero pad.
    input  logic [39:0] i_s_axis_tdata,
    // Bits from low: command[1:0].
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // Bits from low: top_value[31:0], stack_depth[38:32], zero pad.
    output logic [39:0] o_m_axis_tdata,
    // Bits from low: status[1:0], stored[2].
    output logic [2:0]  o_m_axis_tuser
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    t_ctrl                 ctrl;
    logic [PC_W-1:0]       r_pc;
    logic [PC_W-1:0]       n_pc;

    logic [1:0]            r_cmd;
    logic [DATA_W-1:0]     r_lit;
    logic [VIDX_W-1:0]     r_vidx;
    logic [1:0]            r_op;

    logic [SPW-1:0]        r_sp;
    logic [DATA_W-1:0]     r_top;
    logic [DATA_W-1:0]     r_vars [NUM_VARS];
    logic [DATA_W-1:0]     r_res;
    logic                  r_given;
    logic                  r_stored;
    logic [1:0]            r_status;

    logic [DATA_W-1:0]     r_quo;
    logic [DATA_W-1:0]     r_rem;
    logic [DATA_W-1:0]     r_den;
    logic                  r_qneg;
    logic [DIV_CNT_W-1:0]  r_div_cnt;

    logic                  r_out_valid;
    logic [39:0]           r_out_data;
    logic [2:0]            r_out_user;

    logic                  in_xfer;
    logic [1:0]            status_c;
    logic [SPW-1:0]        sp_m2;
    logic [DATA_W-1:0]     ram_rd;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_W-1:0]     ram_wdata;
    logic [DATA_W-1:0]     push_val;
    logic [DATA_W-1:0]     var_val;
    logic [DATA_W-1:0]     prod;
    logic [DATA_W:0]       trial;
    logic [DATA_W:0]       diff;
    logic [DATA_W-1:0]     cur_top;
    logic [SPW+DEPTH_OUT_W-1:0] sp_ext;
    logic                  out_busy;

    assign ctrl            = program_rom(r_pc);
    assign o_s_axis_tready = ctrl.ready;
    assign in_xfer         = i_s_axis_tvalid && ctrl.ready;
    assign out_busy        = r_out_valid && !i_m_axis_tready;

    assign sp_m2 = r_sp - SPW'(2);
    assign var_val  = (r_vidx < VIDX_W'(NUM_VARS)) ? r_vars[r_vidx] : '0;
    assign push_val = (r_cmd == CMD_PUSH_LIT) ? r_lit : var_val;
    assign prod     = ram_rd * r_top;
    assign trial    = {r_rem, r_quo[DATA_W-1]};
    assign diff     = trial - {1'b0, r_den};
    assign cur_top  = (r_sp == '0) ? '0 : r_top;
    assign sp_ext   = {{DEPTH_OUT_W{1'b0}}, r_sp};

    always_comb begin
        status_c = ST_OK;
        case (r_cmd)
            CMD_PUSH_LIT, CMD_PUSH_VAR: begin
                if (r_sp >= SPW'(STACK_DEPTH)) begin
                    status_c = ST_OVERFLOW;
                end
            end
            CMD_APPLY: begin
                if (r_sp < SPW'(2)) begin
                    status_c = ST_UNDERFLOW;
                end else if (r_op == OP_DIV && r_top == '0) begin
                    status_c = ST_DIV_ZERO;
                end
            end
            CMD_STORE: begin
                if (r_sp == '0) begin
                    status_c = ST_UNDERFLOW;
                end
            end
            default: status_c = ST_OK;
        endcase
    end

    always_comb begin
        n_pc = r_pc;
        case (ctrl.jmp)
            JMP_NEXT:   n_pc = r_pc + PC_W'(1);
            JMP_GOTO:   n_pc = ctrl.target;
            JMP_ACCEPT: n_pc = in_xfer ? ctrl.target : r_pc;
            JMP_DECODE: begin
                if (status_c != ST_OK) begin
                    n_pc = ctrl.target;
                end else begin
                    case (r_cmd)
                        CMD_APPLY: n_pc = STEP_ALU;
                        CMD_STORE: n_pc = STEP_STORE;
                        default:   n_pc = STEP_PUSH;
                    endcase
                end
            end
            JMP_DIVSEL:  n_pc = (r_op == OP_DIV) ? STEP_DIV : ctrl.target;
            JMP_DIVLOOP: n_pc = (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) ? ctrl.target : r_pc;
            JMP_OUT:     n_pc = out_busy ? r_pc : ctrl.target;
            default:     n_pc = STEP_WAIT;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_sp[AW-1:0];
        ram_wdata = push_val;
        case (ctrl.act)
            ACT_PUSH: ram_we = 1'b1;
            ACT_WB: begin
                ram_we    = 1'b1;
                ram_waddr = sp_m2[AW-1:0];
                ram_wdata = r_res;
            end
            default: ram_we = 1'b0;
        endcase
    end

    pse_ram #(
        .WIDTH(DATA_W),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk    (i_clk),
        .i_wr_en  (ram_we),
        .i_wr_addr(ram_waddr),
        .i_wr_data(ram_wdata),
        .i_rd_addr(sp_m2[AW-1:0]),
        .o_rd_data(ram_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= STEP_WAIT;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_VARS; i++) begin
                r_vars[i] <= '0;
            end
        end else begin
            r_pc <= n_pc;
            if (ctrl.act == ACT_REPORT && !out_busy) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (in_xfer) begin
                r_lit    <= i_s_axis_tdata[31:0];
                r_vidx   <= i_s_axis_tdata[36:32];
                r_op     <= i_s_axis_tdata[38:37];
                r_cmd    <= i_s_axis_tuser;
                r_given  <= 1'b0;
                r_stored <= 1'b0;
            end
            case (ctrl.act)
                ACT_CHECK: r_status <= status_c;
                ACT_PUSH: begin
                    r_top <= push_val;
                    r_sp  <= r_sp + SPW'(1);
                end
                ACT_ALU: begin
                    case (r_op)
                        OP_ADD:  r_res <= ram_rd + r_top;
                        OP_SUB:  r_res <= ram_rd - r_top;
                        OP_MUL:  r_res <= prod;
                        default: r_res <= '0;
                    endcase
                    r_quo     <= ram_rd[DATA_W-1] ? -ram_rd : ram_rd;
                    r_den     <= r_top[DATA_W-1] ? -r_top : r_top;
                    r_rem     <= '0;
                    r_qneg    <= ram_rd[DATA_W-1] ^ r_top[DATA_W-1];
                    r_div_cnt <= '0;
                end
                ACT_DIV: begin
                    r_quo     <= {r_quo[DATA_W-2:0], !diff[DATA_W]};
                    r_rem     <= diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
                    r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
                end
                ACT_FIX: r_res <= r_qneg ? -r_quo : r_quo;
                ACT_WB: begin
                    r_top <= r_res;
                    r_sp  <= r_sp - SPW'(1);
                end
                ACT_STORE: begin
                    if (r_vidx < VIDX_W'(NUM_VARS)) begin
                        r_vars[r_vidx] <= r_top;
                        r_stored       <= 1'b1;
                    end
                    r_res   <= r_top;
                    r_given <= 1'b1;
                    r_sp    <= '0;
                end
                ACT_REPORT: begin
                    if (!out_busy) begin
                        r_out_data  <= {1'b0, sp_ext[DEPTH_OUT_W-1:0],
                                        r_given ? r_res : cur_top};
                        r_out_user  <= {r_stored, r_status};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the postfix stack evaluator: directed tokens, then random ones.
`timescale 1ns / 1ps

module tb_top;
    import pse_pkg::*;

    localparam int STK_MAX      = STACK_DEPTH_DEF;
    localparam int RAND_TOKENS  = 1700;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 300;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] top;
        logic [6:0]  depth;
        logic        stored;
    } t_result;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] lit;
        logic [4:0]  vidx;
        logic [1:0]  op;
        logic [6:0]  reps;
        logic        known;
        t_result     want;
    } t_script_row;

    localparam t_result NO_RES = '0;

    localparam t_script_row TOKEN_SCRIPT [26] = '{
        '{CMD_STORE,    32'h0000_0000, 5'd0,  OP_ADD, 7'd1,  1'b1,
          '{ST_UNDERFLOW, 32'h0000_0000, 7'd0, 1'b0}},
        '{CMD_APPLY,    32'h0000_0000, 5'd0,  OP_ADD, 7'd1,  1'b1,
          '{ST_UNDERFLOW, 32'h0000_0000, 7'd0, 1'b0}},
        '{CMD_PUSH_VAR, 32'h0000_0000, 5'd0,  OP_ADD, 7'd1,  1'b1,
          '{ST_OK, 32'h0000_0000, 7'd1, 1'b0}},
        '{CMD_PUSH_VAR, 32'hFFFF_FFFF, 5'd31, OP_DIV, 7'd1,  1'b1,
          '{ST_OK, 32'h0000_0000, 7'd2, 1'b0}},
        '{CMD_APPLY,    32'h0000_0000, 5'd0,  OP_DIV, 7'd1,  1'b1,
          '{ST_DIV_ZERO, 32'h0000_0000, 7'd2, 1'b0}},
        '{CMD_STORE,    32'h0000_0000, 5'd25, OP_ADD, 7'd1,  1'b1,
          '{ST_OK, 32'h0000_0000, 7'd0, 1'b1}},
        '{CMD_PUSH_LIT, 32'h8000_0000, 5'd0,  OP_ADD, 7'd1,  1'b1,
          '{ST_OK, 32'h8000_0000, 7'd1, 1'b0}},
        '{CMD_PUSH_LIT, 32'hFFFF_FFFF, 5'd0,  OP_ADD, 7'd1,  1'b1,
          '{ST_OK, 32'hFFFF_FFFF, 7'd2, 1'b0}},
        '{CMD_APPLY,    32'h0000_0000, 5'd0,  OP_DIV, 7'd1,  1'b1,
          '{ST_OK, 32'h8000_0000, 7'd1, 1'b0}},
        '{CMD_PUSH_LIT, 32'h7FFF_FFFF, 5'd0,  OP_ADD, 7'd1,  1'b1,
          '{ST_OK, 32'h7FFF_FFFF, 7'd2, 1'b0}},
        '{CMD_APPLY,    32'h0000_0000, 5'd0,  OP_ADD, 7'd1,  1'b1,
          '{ST_OK, 32'hFFFF_FFFF, 7'd1, 1'b0}},
        '{CMD_PUSH_LIT, 32'h0000_0007, 5'd0,  OP_ADD, 7'd1,  1'b0, NO_RES},
        '{CMD_PUSH_LIT, 32'hFFFF_FFFE, 5'd0,  OP_ADD, 7'd1,  1'b0, NO_RES},
        '{CMD_APPLY,    32'h0000_0000, 5'd0,  OP_DIV, 7'd1,  1'b0, NO_RES},
        '{CMD_APPLY,    32'h0000_0000, 5'd0,  OP_SUB, 7'd1,  1'b0, NO_RES},
        '{CMD_PUSH_LIT, 32'h0000_3039, 5'd0,  OP_ADD, 7'd1,  1'b0, NO_RES},
        '{CMD_APPLY,    32'h0000_0000, 5'd0,  OP_MUL, 7'd1,  1'b0, NO_RES},
        '{CMD_STORE,    32'hFFFF_FFFF, 5'd31, OP_DIV, 7'd1,  1'b0, NO_RES},
        '{CMD_PUSH_VAR, 32'h0000_0000, 5'd31, OP_ADD, 7'd1,  1'b1,
          '{ST_OK, 32'h0000_0000, 7'd1, 1'b0}},
        '{CMD_STORE,    32'h0000_0000, 5'd0,  OP_ADD, 7'd1,  1'b1,
          '{ST_OK, 32'h0000_0000, 7'd0, 1'b1}},
        '{CMD_PUSH_LIT, 32'h5A5A_5A5A, 5'd0,  OP_ADD, 7'd64, 1'b0, NO_RES},
        '{CMD_PUSH_LIT, 32'h0000_0001, 5'd0,  OP_ADD, 7'd1,  1'b1,
          '{ST_OVERFLOW, 32'h5A5A_5A5A, 7'd64, 1'b0}},
        '{CMD_PUSH_VAR, 32'h0000_0000, 5'd0,  OP_ADD, 7'd1,  1'b1,
          '{ST_OVERFLOW, 32'h5A5A_5A5A, 7'd64, 1'b0}},
        '{CMD_APPLY,    32'h0000_0000, 5'd0,  OP_MUL, 7'd1,  1'b0, NO_RES},
        '{CMD_STORE,    32'h0000_0000, 5'd7,  OP_ADD, 7'd1,  1'b0, NO_RES},
        '{CMD_PUSH_VAR, 32'h0000_0000, 5'd7,  OP_ADD, 7'd1,  1'b0, NO_RES}
    };

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [39:0] s_data  = '0;
    logic [1:0]  s_user  = '0;
    logic        m_ready = 1'b0;
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire  [39:0] o_m_axis_tdata;
    wire  [2:0]  o_m_axis_tuser;

    logic [31:0] stack_mem [STK_MAX];
    int unsigned stack_ptr;
    logic [31:0] var_regs [NUM_VARS];
    t_result     pending_results [$];

    int src_idle_pct = 24;
    int snk_idle_pct = 77;
    int hold_token   = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int cycle_cnt    = 0;
    int n_errors     = 0;
    int n_checked    = 0;
    int n_sent       = 0;
    int n_overflow   = 0;
    int n_underflow  = 0;
    int n_divzero    = 0;
    int n_writes     = 0;

    postfix_stack_evaluator #(
        .STACK_DEPTH(STK_MAX)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_result eval_token(input logic [1:0] cmd, input logic [31:0] lit,
                                           input logic [4:0] vidx, input logic [1:0] op);
        t_result            res;
        logic signed [31:0] lhs;
        logic signed [31:0] rhs;
        logic [31:0]        acc;
        logic               ok;
        res        = '0;
        res.status = ST_OK;
        acc        = '0;
        ok         = 1'b1;
        case (cmd)
            CMD_PUSH_LIT, CMD_PUSH_VAR: begin
                if (stack_ptr >= STK_MAX) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    if (cmd == CMD_PUSH_LIT) begin
                        stack_mem[stack_ptr] = lit;
                    end else begin
                        stack_mem[stack_ptr] = (vidx < NUM_VARS) ? var_regs[vidx] : '0;
                    end
                    stack_ptr++;
                end
            end
            CMD_APPLY: begin
                if (stack_ptr < 2) begin
                    res.status = ST_UNDERFLOW;
                end else begin
                    lhs = stack_mem[stack_ptr-2];
                    rhs = stack_mem[stack_ptr-1];
                    case (op)
                        OP_ADD: acc = lhs + rhs;
                        OP_SUB: acc = lhs - rhs;
                        OP_MUL: acc = lhs * rhs;
                        default: begin
                            if (rhs == 0) begin
                                ok         = 1'b0;
                                res.status = ST_DIV_ZERO;
                            end else if (lhs == 32'sh8000_0000 && rhs == -1) begin
                                acc = lhs;
                            end else begin
                                acc = lhs / rhs;
                            end
                        end
                    endcase
                    if (ok) begin
                        stack_ptr--;
                        stack_mem[stack_ptr-1] = acc;
                    end
                end
            end
            default: begin
                if (stack_ptr == 0) begin
                    res.status = ST_UNDERFLOW;
                end else begin
                    res.top = stack_mem[stack_ptr-1];
                    if (vidx < NUM_VARS) begin
                        var_regs[vidx] = res.top;
                        res.stored     = 1'b1;
                    end
                    stack_ptr = 0;
                end
            end
        endcase
        if (!(cmd == CMD_STORE && res.status == ST_OK)) begin
            res.top = (stack_ptr == 0) ? '0 : stack_mem[stack_ptr-1];
        end
        res.depth = 7'(stack_ptr);
        case (res.status)
            ST_OVERFLOW:  n_overflow++;
            ST_UNDERFLOW: n_underflow++;
            ST_DIV_ZERO:  n_divzero++;
            default:      n_writes += res.stored;
        endcase
        return res;
    endfunction

    task automatic send_token(input logic [1:0] cmd, input logic [31:0] lit,
                              input logic [4:0] vidx, input logic [1:0] op,
                              input logic known, input t_result want);
        t_result predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= cmd;
        s_data  <= {1'b0, op, vidx, lit};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted = eval_token(cmd, lit, vidx, op);
        pending_results.push_back(known ? want : predicted);
        n_sent++;
    endtask

    task automatic wait_all_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic flag_mismatch(input string field, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
        n_errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_val, act_val);
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            got = {o_m_axis_tuser[1:0], o_m_axis_tdata[31:0], o_m_axis_tdata[38:32],
                   o_m_axis_tuser[2]};
            if (pending_results.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected transfer, expected none, %s %0d top %h depth %0d",
                         $time, "got status", got.status, got.top, got.depth);
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (got.status !== want.status) flag_mismatch("status", want.status, got.status);
                if (got.top !== want.top) flag_mismatch("top_value", want.top, got.top);
                if (got.depth !== want.depth) flag_mismatch("stack_depth", want.depth, got.depth);
                if (got.stored !== want.stored) flag_mismatch("stored", want.stored, got.stored);
            end
        end
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= LONG_HOLD;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_cnt, pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [1:0]  cmd;
        logic [31:0] lit;
        logic [4:0]  vidx;
        logic [1:0]  op;
        int          fill_left;
        int          roll;
        fill_left = 0;
        stack_ptr = 0;
        foreach (var_regs[v]) var_regs[v] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (TOKEN_SCRIPT[r]) begin
            for (int k = 0; k < TOKEN_SCRIPT[r].reps; k++) begin
                send_token(TOKEN_SCRIPT[r].cmd, TOKEN_SCRIPT[r].lit, TOKEN_SCRIPT[r].vidx,
                           TOKEN_SCRIPT[r].op, TOKEN_SCRIPT[r].known, TOKEN_SCRIPT[r].want);
            end
        end
        wait_all_results();

        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 77 : 0;
            snk_idle_pct <= (phase == 0) ? 77 : (phase == 1) ? 24 : 0;
            // With the output held off, the block fills up and must stall its input.
            if (phase == 2) hold_token <= hold_token + 1;
            for (int n = 0; n < RAND_TOKENS / 3; n++) begin
                case ($urandom_range(9))
                    0:       lit = 32'h8000_0000;
                    1:       lit = 32'h7FFF_FFFF;
                    2:       lit = '0;
                    3:       lit = '1;
                    4, 5:    lit = 32'($urandom_range(40)) - 32'd20;
                    default: lit = $urandom;
                endcase
                vidx = ($urandom_range(15) == 0) ? 5'($urandom_range(31, 26))
                                                 : 5'($urandom_range(25));
                op   = 2'($urandom_range(3));
                if (fill_left == 0 && $urandom_range(299) == 0) fill_left = 68;
                roll = $urandom_range(99);
                if (fill_left > 0) begin
                    fill_left--;
                    cmd = (roll < 50) ? CMD_PUSH_VAR : CMD_PUSH_LIT;
                end else if (roll < 8) begin
                    cmd = 2'($urandom_range(3));
                end else begin
                    roll = $urandom_range(99);
                    if (stack_ptr < 2) begin
                        cmd = (stack_ptr == 1 && roll < 15) ? CMD_STORE :
                              (roll < 70) ? CMD_PUSH_LIT : CMD_PUSH_VAR;
                    end else if (roll < ((stack_ptr > 8) ? 15 : 45)) begin
                        cmd = (roll % 3 == 0) ? CMD_PUSH_VAR : CMD_PUSH_LIT;
                    end else if (roll < 90) begin
                        cmd = CMD_APPLY;
                    end else begin
                        cmd = CMD_STORE;
                    end
                end
                send_token(cmd, lit, vidx, op, 1'b0, NO_RES);
            end
            wait_all_results();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d tokens and checked %0d results under three stall patterns.",
                 n_sent, n_checked);
        $display("Faults seen: %0d overflow, %0d underflow, %0d divide by zero; %0d stores.",
                 n_overflow, n_underflow, n_divzero, n_writes);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
